FILE: hdl/pft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types and constants for the protobuf field tokenizer.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int unsigned BUFFER_BYTES = 65536;

    localparam int unsigned POS_W   = 17;
    localparam int unsigned FIELD_W = 61;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned IDX_W   = 4;

    localparam logic [VALUE_W-1:0] LEN_LIMIT = VALUE_W'(BUFFER_BYTES);
    localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};
    localparam logic [IDX_W-1:0]   VARINT_LAST_IDX = IDX_W'(9);

    localparam int unsigned TDATA_W = 160;

    localparam logic [KIND_W-1:0] KIND_VARINT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIXED64 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LEN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIXED32 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_VARINT,
        PH_FIXED,
        PH_LEN,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } beat_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] field_number;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   data_offset;
        logic [POS_W-1:0]   data_length;
        logic               is_last;
    } result_t;

endpackage

FILE: hdl/pft_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_in_reg
// Input register: holds one byte beat until the decoder takes it.
// ----------------------------------------------------------------------------
module pft_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // in_byte [7:0]
    input  logic          s_axis_tlast,
    input  logic          take,
    output logic          beat_valid,
    output pft_pkg::beat_t beat
);
    import pft_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    assign s_axis_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tready)
        begin
            valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            beat_reg.in_byte <= s_axis_tdata;
            beat_reg.in_last <= s_axis_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

FILE: hdl/pft_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_core
// Tokenizer state and per-byte update: key varint, body decode, skip, errors.
// ----------------------------------------------------------------------------
module pft_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  pft_pkg::beat_t   beat,
    output logic             res_hit,
    output pft_pkg::result_t res
);
    import pft_pkg::*;

    phase_t               phase_reg,  phase_next;
    logic [POS_W-1:0]     pos_reg,    pos_next;
    logic [VALUE_W-1:0]   acc_reg,    acc_next;
    logic [IDX_W-1:0]     idx_reg,    idx_next;
    logic [FIELD_W-1:0]   fn_reg,     fn_next;
    logic [2:0]           wt_reg,     wt_next;
    logic [POS_W-1:0]     skip_reg,   skip_next;
    logic [POS_W-1:0]     start_reg,  start_next;
    logic                 failed_reg, failed_next;

    logic [POS_W-1:0]   next_pos;
    logic [6:0]         vshift;
    logic [VALUE_W-1:0] acc_var;
    logic [VALUE_W-1:0] acc_fix;
    logic               vdone;
    logic               vlong;

    assign next_pos = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    // 7 * byte index
    assign vshift   = {idx_reg, 3'b000} - {3'b000, idx_reg};
    assign acc_var  = acc_reg | ({57'd0, beat.in_byte[6:0]} << vshift);
    assign acc_fix  = acc_reg | ({56'd0, beat.in_byte} << {idx_reg[2:0], 3'b000});
    assign vdone    = !beat.in_byte[7];
    assign vlong    = beat.in_byte[7] && (idx_reg >= VARINT_LAST_IDX);

    always_comb
    begin
        logic done;
        logic err;
        logic last;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   off;
        logic [POS_W-1:0]   len;

        done = 1'b0;
        err  = 1'b0;
        last = beat.in_last;
        kind = KIND_VARINT;
        val  = '0;
        off  = '0;
        len  = '0;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        idx_next    = idx_reg;
        fn_next     = fn_reg;
        wt_next     = wt_reg;
        skip_next   = skip_reg;
        start_next  = start_reg;
        failed_next = failed_reg;
        res_hit     = 1'b0;

        if (step)
        begin
            if (failed_reg)
            begin
                if (last)
                begin
                    phase_next  = PH_KEY;
                    pos_next    = '0;
                    acc_next    = '0;
                    idx_next    = '0;
                    fn_next     = '0;
                    wt_next     = '0;
                    skip_next   = '0;
                    start_next  = '0;
                    failed_next = 1'b0;
                end
                else
                begin
                    pos_next = next_pos;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_KEY:
                    begin
                        acc_next = acc_var;
                        if (vlong)
                        begin
                            err = 1'b1;
                        end
                        else if (vdone)
                        begin
                            fn_next  = acc_var[VALUE_W-1:3];
                            wt_next  = acc_var[2:0];
                            acc_next = '0;
                            idx_next = '0;
                            unique case (acc_var[2:0])
                                WT_VARINT:  phase_next = PH_VARINT;
                                WT_FIXED64: phase_next = PH_FIXED;
                                WT_FIXED32: phase_next = PH_FIXED;
                                WT_LEN:     phase_next = PH_LEN;
                                default:    err        = 1'b1;
                            endcase
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    PH_VARINT:
                    begin
                        acc_next = acc_var;
                        if (vlong)
                        begin
                            err = 1'b1;
                        end
                        else if (vdone)
                        begin
                            done = 1'b1;
                            kind = KIND_VARINT;
                            val  = acc_var;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    PH_FIXED:
                    begin
                        acc_next = acc_fix;
                        idx_next = idx_reg + IDX_W'(1);
                        if (wt_reg == WT_FIXED64)
                        begin
                            if (idx_reg[2:0] == 3'd7)
                            begin
                                done = 1'b1;
                                kind = KIND_FIXED64;
                                val  = acc_fix;
                            end
                        end
                        else if (idx_reg[1:0] == 2'd3)
                        begin
                            done = 1'b1;
                            kind = KIND_FIXED32;
                            val  = acc_fix;
                        end
                    end
                    PH_LEN:
                    begin
                        acc_next = acc_var;
                        if (vlong)
                        begin
                            err = 1'b1;
                        end
                        else if (vdone)
                        begin
                            if (acc_var > LEN_LIMIT)
                            begin
                                err = 1'b1;
                            end
                            else
                            begin
                                start_next = next_pos;
                                if (acc_var == '0)
                                begin
                                    done = 1'b1;
                                    kind = KIND_LEN;
                                    off  = next_pos;
                                end
                                else
                                begin
                                    skip_next  = acc_var[POS_W-1:0];
                                    idx_next   = '0;
                                    phase_next = PH_SKIP;
                                end
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    PH_SKIP:
                    begin
                        if (skip_reg != '0)
                        begin
                            skip_next = skip_reg - POS_W'(1);
                        end
                        if (skip_reg <= POS_W'(1))
                        begin
                            done = 1'b1;
                            kind = KIND_LEN;
                            off  = start_reg;
                            len  = acc_reg[POS_W-1:0];
                        end
                    end
                    default:
                    begin
                        err = 1'b1;
                    end
                endcase

                if (!done && !err && last)
                begin
                    err = 1'b1;
                end

                if (!done && !err)
                begin
                    pos_next = next_pos;
                end
                else
                begin
                    res_hit = 1'b1;
                    if (last)
                    begin
                        phase_next  = PH_KEY;
                        pos_next    = '0;
                        acc_next    = '0;
                        idx_next    = '0;
                        fn_next     = '0;
                        wt_next     = '0;
                        skip_next   = '0;
                        start_next  = '0;
                        failed_next = 1'b0;
                    end
                    else
                    begin
                        pos_next    = next_pos;
                        phase_next  = PH_KEY;
                        acc_next    = '0;
                        idx_next    = '0;
                        skip_next   = '0;
                        failed_next = err;
                    end
                end
            end
        end

        if (err)
        begin
            res.kind         = KIND_ERROR;
            res.field_number = '0;
            res.value        = '0;
            res.data_offset  = '0;
            res.data_length  = '0;
        end
        else
        begin
            res.kind         = kind;
            res.field_number = fn_reg;
            res.value        = val;
            res.data_offset  = off;
            res.data_length  = len;
        end
        res.is_last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_KEY;
            pos_reg    <= '0;
            acc_reg    <= '0;
            idx_reg    <= '0;
            fn_reg     <= '0;
            wt_reg     <= '0;
            skip_reg   <= '0;
            start_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            acc_reg    <= acc_next;
            idx_reg    <= idx_next;
            fn_reg     <= fn_next;
            wt_reg     <= wt_next;
            skip_reg   <= skip_next;
            start_reg  <= start_next;
            failed_reg <= failed_next;
        end
    end

endmodule

FILE: hdl/pft_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_out_reg
// Result register: holds one token beat until the receiver takes it.
// ----------------------------------------------------------------------------
module pft_out_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  pft_pkg::result_t             res,
    output logic                         free,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pft_pkg::TDATA_W-1:0]  m_axis_tdata,  // field_number, value,
                                                        // data_offset, data_length
    output logic [pft_pkg::KIND_W-1:0]   m_axis_tuser,  // kind
    output logic                         m_axis_tlast   // is_last
);
    import pft_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.is_last;
    assign m_axis_tdata  = {1'b0, res_reg.data_length, res_reg.data_offset,
                            res_reg.value, res_reg.field_number};

endmodule

FILE: hdl/protobuf_field_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_field_tokenizer
// Splits a protobuf wire-format byte stream into field tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one message byte per beat; tlast marks the buffer's last
//   byte. Master side gives one token per completed field or per fault:
//   tuser = kind, tdata = field number, value, payload offset and length,
//   tlast = token closes the buffer. Bytes inside a field give no beat.
// Path: a byte that completes a field is held in the input register, then
//   its token in the result register, before the master side shows it.
// Throughput: one byte per cycle while the result register is free; the
//   per-byte update is a single pass through the decode logic between the
//   two registers.
// Reset: rst_n clears the decoder to expect a key at position zero and
//   empties both registers.
// Stall: while the result register is held, the input register holds its
//   byte and tready drops once it is full; nothing is dropped.
// After a fault the block emits an error token and ignores bytes until the
//   buffer's last byte, which restarts it.
// ----------------------------------------------------------------------------
module protobuf_field_tokenizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // in_byte [7:0]
    input  logic                         s_axis_tlast,   // in_last
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pft_pkg::TDATA_W-1:0]  m_axis_tdata,   // field_number [60:0],
                                                         // value [124:61],
                                                         // data_offset [141:125],
                                                         // data_length [158:142]
    output logic [pft_pkg::KIND_W-1:0]   m_axis_tuser,   // kind [2:0]
    output logic                         m_axis_tlast    // is_last
);
    import pft_pkg::*;

    logic    beat_valid;
    beat_t   beat;
    logic    out_free;
    logic    step;
    logic    res_hit;
    result_t res;

    assign step = beat_valid && out_free;

    pft_in_reg u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .take          (step),
        .beat_valid    (beat_valid),
        .beat          (beat)
    );

    pft_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .beat    (beat),
        .res_hit (res_hit),
        .res     (res)
    );

    pft_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step && res_hit),
        .res           (res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
